FILE: hw/rtl/rcmw_pkg.sv
// Shared types, register map and constants for the mecanum wheel speed block.
package rcmw_pkg;

  localparam int CHANNEL_WIDTH_DEF = 12;
  localparam int EXT_W = 17;
  localparam int Q_BITS = 15;
  localparam int LANE_STAGES = Q_BITS + 2;
  localparam int ADDR_W = 5;

  localparam logic [9:0]  DEADZONE_RST  = 10'd20;
  localparam logic [10:0] FULL_RST      = 11'd820;
  localparam logic [10:0] THRESHOLD_RST = 11'd400;
  localparam logic [14:0] LOW_RST       = 15'd9830;
  localparam logic [14:0] MEDIUM_RST    = 15'd19661;
  localparam logic [14:0] HIGH_RST      = 15'd32767;
  localparam logic [13:0] RPM_RST       = 14'd8000;

  typedef enum logic [1:0] {
    DS_OFFLINE = 2'd0,
    DS_LOCKED  = 2'd1,
    DS_ENABLED = 2'd2
  } drive_state_t;

  typedef enum logic [1:0] {
    GEAR_LOW    = 2'd0,
    GEAR_MEDIUM = 2'd1,
    GEAR_HIGH   = 2'd2
  } gear_t;

  typedef enum logic [2:0] {
    REG_DEADZONE   = 3'd0,
    REG_FULL_SCALE = 3'd1,
    REG_THRESHOLD  = 3'd2,
    REG_LOW_LIMIT  = 3'd3,
    REG_MED_LIMIT  = 3'd4,
    REG_HIGH_LIMIT = 3'd5,
    REG_MOTOR_RPM  = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [9:0]  deadzone;
    logic [10:0] full;
    logic [13:0] rpm;
  } cfg_t;

  typedef struct packed {
    drive_state_t state;
    gear_t        gear;
    logic [14:0]  limit;
  } side_t;

endpackage

FILE: hw/rtl/rc_to_mecanum_wheel_speeds_top.sv
// Top level: register port, switch decode, lane pipeline and its flow control.
//
//   channel  direction  handshake          content
//   in       sink       in_valid/in_stall   one remote-control frame word
//   out      source     out_valid/out_stall one drive state, commands, wheel rpm word
//   cfg      sink       APB                 seven configuration registers
//
// The pipeline has 37 stages, and one word is accepted per cycle while in_stall is low.
// The depth is set by the two 15-step restoring dividers (normalization and
// desaturation), each one stage per quotient bit, plus decode, multiply and mix stages.
// Each stage holds while the next one is full and held, so bubbles close up.
// Reset clears the stage valid bits and loads the register defaults.
module rc_to_mecanum_wheel_speeds_top
  import rcmw_pkg::*;
#(
  parameter int CHANNEL_WIDTH = CHANNEL_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ADDR_W-1:0]               paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            link_online,
  input  logic signed [CHANNEL_WIDTH-1:0] enable_switch,
  input  logic signed [CHANNEL_WIDTH-1:0] gear_switch,
  input  logic signed [CHANNEL_WIDTH-1:0] stick_vx,
  input  logic signed [CHANNEL_WIDTH-1:0] stick_vy,
  input  logic signed [CHANNEL_WIDTH-1:0] stick_wz,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      drive_state,
  output logic [1:0]                      gear,
  output logic signed [15:0]              cmd_vx,
  output logic signed [15:0]              cmd_vy,
  output logic signed [15:0]              cmd_wz,
  output logic signed [14:0]              wheel_0_rpm,
  output logic signed [14:0]              wheel_1_rpm,
  output logic signed [14:0]              wheel_2_rpm,
  output logic signed [14:0]              wheel_3_rpm
);

  localparam int NORM_FIRST = 1;
  localparam int MIX_FIRST = NORM_FIRST + LANE_STAGES;
  localparam int DESAT_FIRST = MIX_FIRST + 2;
  localparam int NST = DESAT_FIRST + LANE_STAGES;
  localparam int CMD_ST = NST - MIX_FIRST;

  logic [9:0]  deadzone;
  logic [10:0] full_scale;
  logic [10:0] threshold;
  logic [14:0] low_limit;
  logic [14:0] med_limit;
  logic [14:0] high_limit;
  logic [13:0] full_rpm;
  reg_index_t  widx;
  cfg_t        cfg;

  logic [NST-1:0] v;
  logic [NST-1:0] en;
  side_t sb [NST];
  side_t dec;
  logic signed [15:0] cmdsb [CMD_ST][3];
  logic signed [CHANNEL_WIDTH-1:0] stk [3];
  logic signed [15:0] lane_cmd [3];
  logic signed [17:0] mix_wheel [4];
  logic [16:0] mix_max;
  logic mix_desat;
  logic signed [14:0] wrpm [4];
  logic signed [EXT_W-1:0] en_x, gs_x, th_x;

  assign pready = 1'b1;
  assign widx = reg_index_t'(paddr[ADDR_W-1:2]);
  assign cfg = '{deadzone: deadzone, full: full_scale, rpm: full_rpm};

  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone   <= DEADZONE_RST;
      full_scale <= FULL_RST;
      threshold  <= THRESHOLD_RST;
      low_limit  <= LOW_RST;
      med_limit  <= MEDIUM_RST;
      high_limit <= HIGH_RST;
      full_rpm   <= RPM_RST;
    end else if (psel && penable && pwrite) begin
      case (widx)
        REG_DEADZONE:   deadzone   <= pwdata[9:0];
        REG_FULL_SCALE: full_scale <= pwdata[10:0];
        REG_THRESHOLD:  threshold  <= pwdata[10:0];
        REG_LOW_LIMIT:  low_limit  <= pwdata[14:0];
        REG_MED_LIMIT:  med_limit  <= pwdata[14:0];
        REG_HIGH_LIMIT: high_limit <= pwdata[14:0];
        REG_MOTOR_RPM:  full_rpm   <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_DEADZONE:   prdata = 32'(deadzone);
      REG_FULL_SCALE: prdata = 32'(full_scale);
      REG_THRESHOLD:  prdata = 32'(threshold);
      REG_LOW_LIMIT:  prdata = 32'(low_limit);
      REG_MED_LIMIT:  prdata = 32'(med_limit);
      REG_HIGH_LIMIT: prdata = 32'(high_limit);
      REG_MOTOR_RPM:  prdata = 32'(full_rpm);
      default:        prdata = '0;
    endcase
  end

  assign en_x = EXT_W'(enable_switch);
  assign gs_x = EXT_W'(gear_switch);
  assign th_x = $signed(EXT_W'(threshold));

  always_comb begin
    dec = '{state: DS_OFFLINE, gear: GEAR_LOW, limit: low_limit};
    if (link_online) begin
      if (gs_x < -th_x) begin
        dec.gear = GEAR_HIGH;
        dec.limit = high_limit;
      end else if (gs_x > th_x) begin
        dec.gear = GEAR_LOW;
        dec.limit = low_limit;
      end else begin
        dec.gear = GEAR_MEDIUM;
        dec.limit = med_limit;
      end
      dec.state = (en_x < -th_x) ? DS_ENABLED : DS_LOCKED;
    end
  end

  always_comb begin
    en[NST-1] = !v[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];
  assign out_valid = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sb[0]  <= dec;
      stk[0] <= stick_vx;
      stk[1] <= stick_vy;
      stk[2] <= stick_wz;
    end
    for (int k = 1; k < NST; k++) begin
      if (en[k]) begin
        sb[k] <= sb[k-1];
      end
    end
    if (en[MIX_FIRST]) begin
      cmdsb[0] <= lane_cmd;
    end
    for (int k = 1; k < CMD_ST; k++) begin
      if (en[MIX_FIRST+k]) begin
        cmdsb[k] <= cmdsb[k-1];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_axis
    rcmw_norm_lane #(
      .CHANNEL_WIDTH(CHANNEL_WIDTH)
    ) u_norm (
      .clk   (clk),
      .en    (en[NORM_FIRST +: LANE_STAGES]),
      .stick (stk[i]),
      .active(sb[0].state == DS_ENABLED),
      .limit (sb[0].limit),
      .cfg   (cfg),
      .cmd   (lane_cmd[i])
    );
  end

  rcmw_mix u_mix (
    .clk    (clk),
    .en     (en[MIX_FIRST +: 2]),
    .cmd_vx (lane_cmd[0]),
    .cmd_vy (lane_cmd[1]),
    .cmd_wz (lane_cmd[2]),
    .limit  (sb[MIX_FIRST].limit),
    .wheel  (mix_wheel),
    .max_abs(mix_max),
    .desat  (mix_desat)
  );

  for (genvar i = 0; i < 4; i++) begin : g_wheel
    rcmw_desat_lane u_desat (
      .clk      (clk),
      .en       (en[DESAT_FIRST +: LANE_STAGES]),
      .wheel    (mix_wheel[i]),
      .max_abs  (mix_max),
      .desat    (mix_desat),
      .limit    (sb[DESAT_FIRST-1].limit),
      .rpm      (cfg.rpm),
      .wheel_rpm(wrpm[i])
    );
  end

  assign drive_state = sb[NST-1].state;
  assign gear        = sb[NST-1].gear;
  assign cmd_vx      = cmdsb[CMD_ST-1][0];
  assign cmd_vy      = cmdsb[CMD_ST-1][1];
  assign cmd_wz      = cmdsb[CMD_ST-1][2];
  assign wheel_0_rpm = wrpm[0];
  assign wheel_1_rpm = wrpm[1];
  assign wheel_2_rpm = wrpm[2];
  assign wheel_3_rpm = wrpm[3];

endmodule

FILE: hw/rtl/rcmw_norm_lane.sv
// One axis lane: deadzone, clamp, pipelined Q0.15 normalization and limit scaling.
module rcmw_norm_lane
  import rcmw_pkg::*;
#(
  parameter int CHANNEL_WIDTH = CHANNEL_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic [LANE_STAGES-1:0]          en,
  input  logic signed [CHANNEL_WIDTH-1:0] stick,
  input  logic                            active,
  input  logic [14:0]                     limit,
  input  cfg_t                            cfg,
  output logic signed [15:0]              cmd
);

  logic signed [EXT_W-1:0] x;
  logic [EXT_W-1:0] mag;
  logic [EXT_W-1:0] magc;
  logic [10:0] dv;
  logic [10:0] num;
  logic degen;
  logic zero0;
  logic sat0;

  logic [10:0] r [0:Q_BITS];
  logic [14:0] q [0:Q_BITS];
  logic [14:0] lim [0:Q_BITS];
  logic neg [0:Q_BITS];
  logic zero [0:Q_BITS];
  logic sat [0:Q_BITS];

  logic [14:0] n;
  logic [29:0] prod;
  logic [15:0] c;

  assign x = EXT_W'(stick);
  assign mag = x[EXT_W-1] ? EXT_W'(-x) : EXT_W'(x);
  assign dv = cfg.full - 11'(cfg.deadzone);
  assign degen = cfg.full <= {1'b0, cfg.deadzone};
  assign magc = (mag > EXT_W'(cfg.full)) ? EXT_W'(cfg.full) : mag;
  assign num = 11'(magc - EXT_W'(cfg.deadzone));
  assign zero0 = !active || (mag <= EXT_W'(cfg.deadzone));
  assign sat0 = degen || (num >= dv);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      r[0]    <= num;
      q[0]    <= '0;
      lim[0]  <= limit;
      neg[0]  <= x[EXT_W-1];
      zero[0] <= zero0;
      sat[0]  <= sat0;
    end
  end

  for (genvar j = 1; j <= Q_BITS; j++) begin : g_step
    logic [11:0] r2;
    logic ge;
    assign r2 = {r[j-1], 1'b0};
    assign ge = r2 >= {1'b0, dv};
    always_ff @(posedge clk) begin
      if (en[j]) begin
        r[j]    <= ge ? 11'(r2 - {1'b0, dv}) : r2[10:0];
        q[j]    <= {q[j-1][13:0], ge};
        lim[j]  <= lim[j-1];
        neg[j]  <= neg[j-1];
        zero[j] <= zero[j-1];
        sat[j]  <= sat[j-1];
      end
    end
  end

  assign n = sat[Q_BITS] ? 15'h7FFF : q[Q_BITS];
  assign prod = n * lim[Q_BITS];
  assign c = {1'b0, prod[29:15]};

  always_ff @(posedge clk) begin
    if (en[LANE_STAGES-1]) begin
      if (zero[Q_BITS]) begin
        cmd <= '0;
      end else begin
        cmd <= neg[Q_BITS] ? -$signed(c) : $signed(c);
      end
    end
  end

endmodule

FILE: hw/rtl/rcmw_mix.sv
// Merge stage: mixes three axis commands into four wheels and finds the largest magnitude.
module rcmw_mix
  import rcmw_pkg::*;
(
  input  logic               clk,
  input  logic [1:0]         en,
  input  logic signed [15:0] cmd_vx,
  input  logic signed [15:0] cmd_vy,
  input  logic signed [15:0] cmd_wz,
  input  logic [14:0]        limit,
  output logic signed [17:0] wheel [4],
  output logic [16:0]        max_abs,
  output logic               desat
);

  logic signed [17:0] vx, vy, wz;
  logic signed [17:0] wa [4];
  logic [16:0] ab [4];
  logic [16:0] m01, m23, mx;

  assign vx = 18'(cmd_vx);
  assign vy = 18'(cmd_vy);
  assign wz = 18'(cmd_wz);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      wa[0] <= vx - vy - wz;
      wa[1] <= vx + vy + wz;
      wa[2] <= vx + vy - wz;
      wa[3] <= vx - vy + wz;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ab[i] = wa[i][17] ? 17'(-wa[i]) : 17'(wa[i]);
    end
    m01 = (ab[0] > ab[1]) ? ab[0] : ab[1];
    m23 = (ab[2] > ab[3]) ? ab[2] : ab[3];
    mx  = (m01 > m23) ? m01 : m23;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      wheel   <= wa;
      max_abs <= mx;
      desat   <= mx > {2'b0, limit};
    end
  end

endmodule

FILE: hw/rtl/rcmw_desat_lane.sv
// One wheel lane: pipelined proportional desaturation divide and rpm scaling.
module rcmw_desat_lane
  import rcmw_pkg::*;
(
  input  logic               clk,
  input  logic [LANE_STAGES-1:0] en,
  input  logic signed [17:0] wheel,
  input  logic [16:0]        max_abs,
  input  logic               desat,
  input  logic [14:0]        limit,
  input  logic [13:0]        rpm,
  output logic signed [14:0] wheel_rpm
);

  logic [16:0] a;
  logic [31:0] prod0;

  logic [16:0] r [0:Q_BITS];
  logic [14:0] lo [0:Q_BITS];
  logic [14:0] q [0:Q_BITS];
  logic [16:0] dvs [0:Q_BITS];
  logic [14:0] a15 [0:Q_BITS];
  logic neg [0:Q_BITS];
  logic ds [0:Q_BITS];

  logic [14:0] s;
  logic [28:0] p;
  logic [14:0] m;

  assign a = wheel[17] ? 17'(-wheel) : 17'(wheel);
  assign prod0 = a * limit;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      r[0]   <= prod0[31:15];
      lo[0]  <= prod0[14:0];
      q[0]   <= '0;
      dvs[0] <= max_abs;
      a15[0] <= a[14:0];
      neg[0] <= wheel[17];
      ds[0]  <= desat;
    end
  end

  for (genvar j = 1; j <= Q_BITS; j++) begin : g_step
    logic [17:0] r2;
    logic ge;
    assign r2 = {r[j-1], lo[j-1][14]};
    assign ge = r2 >= {1'b0, dvs[j-1]};
    always_ff @(posedge clk) begin
      if (en[j]) begin
        r[j]   <= ge ? 17'(r2 - {1'b0, dvs[j-1]}) : r2[16:0];
        lo[j]  <= {lo[j-1][13:0], 1'b0};
        q[j]   <= {q[j-1][13:0], ge};
        dvs[j] <= dvs[j-1];
        a15[j] <= a15[j-1];
        neg[j] <= neg[j-1];
        ds[j]  <= ds[j-1];
      end
    end
  end

  assign s = ds[Q_BITS] ? q[Q_BITS] : a15[Q_BITS];
  assign p = s * rpm;
  assign m = {1'b0, p[28:15]};

  always_ff @(posedge clk) begin
    if (en[LANE_STAGES-1]) begin
      wheel_rpm <= neg[Q_BITS] ? -$signed(m) : $signed(m);
    end
  end

endmodule

FILE: tb/rc_to_mecanum_wheel_speeds_top_tb.sv
// Self-checking testbench for the remote-control frame to mecanum wheel speed block.
`timescale 1ns / 100ps

module rc_to_mecanum_wheel_speeds_top_tb;
  import rcmw_pkg::*;

  typedef struct packed {
    logic        online;
    logic [11:0] en_sw;
    logic [11:0] gear_sw;
    logic [11:0] vx;
    logic [11:0] vy;
    logic [11:0] wz;
  } frame_t;

  typedef struct packed {
    logic [1:0]  state;
    logic [1:0]  gear;
    logic [15:0] cvx;
    logic [15:0] cvy;
    logic [15:0] cwz;
    logic [14:0] w0;
    logic [14:0] w1;
    logic [14:0] w2;
    logic [14:0] w3;
  } speeds_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  frame_t drv_frame = '0;
  logic [1:0] drive_state, gear;
  logic signed [15:0] cmd_vx, cmd_vy, cmd_wz;
  logic signed [14:0] wheel_0_rpm, wheel_1_rpm, wheel_2_rpm, wheel_3_rpm;

  rc_to_mecanum_wheel_speeds_top u_top (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .link_online(drv_frame.online),
    .enable_switch(drv_frame.en_sw), .gear_switch(drv_frame.gear_sw),
    .stick_vx(drv_frame.vx), .stick_vy(drv_frame.vy), .stick_wz(drv_frame.wz),
    .out_valid(out_valid), .out_stall(out_stall), .drive_state(drive_state),
    .gear(gear), .cmd_vx(cmd_vx), .cmd_vy(cmd_vy), .cmd_wz(cmd_wz),
    .wheel_0_rpm(wheel_0_rpm), .wheel_1_rpm(wheel_1_rpm),
    .wheel_2_rpm(wheel_2_rpm), .wheel_3_rpm(wheel_3_rpm)
  );

  always #4 clk = ~clk;

  int unsigned dz_q, full_q, thr_q, rpm_q;
  int unsigned limit_q [3];
  frame_t pending_frames[$];
  speeds_t expected_speeds[$];
  int unsigned send_idle_pct, recv_idle_pct;
  int mismatches, frames_sent, words_seen, idle_cycles;
  int n_locked, n_enabled, n_offline;
  bit timed_out;
  bit in_taken;

  function automatic int axis_cmd(logic [11:0] raw, int unsigned lim);
    int v;
    int unsigned mag, n;
    v = $signed(raw);
    mag = v < 0 ? -v : v;
    if (mag <= dz_q) return 0;
    if (full_q <= dz_q) n = 32767;
    else begin
      if (mag > full_q) mag = full_q;
      n = ((mag - dz_q) * 32768) / (full_q - dz_q);
      if (n > 32767) n = 32767;
    end
    n = (n * lim) >> 15;
    return v < 0 ? -int'(n) : int'(n);
  endfunction

  function automatic speeds_t wheel_speeds(frame_t f);
    speeds_t r;
    int th, en, gs, c[3], w[4];
    int unsigned lim, mx;
    longint unsigned a;
    r = '0;
    if (f.online) begin
      th = thr_q;
      en = $signed(f.en_sw);
      gs = $signed(f.gear_sw);
      if (gs < -th) r.gear = GEAR_HIGH;
      else if (gs > th) r.gear = GEAR_LOW;
      else r.gear = GEAR_MEDIUM;
      lim = limit_q[r.gear];
      if (en >= -th) r.state = DS_LOCKED;
      else begin
        r.state = DS_ENABLED;
        c[0] = axis_cmd(f.vx, lim);
        c[1] = axis_cmd(f.vy, lim);
        c[2] = axis_cmd(f.wz, lim);
        w[0] = c[0] - c[1] - c[2];
        w[1] = c[0] + c[1] + c[2];
        w[2] = c[0] + c[1] - c[2];
        w[3] = c[0] - c[1] + c[2];
        mx = 0;
        foreach (w[i]) if ((w[i] < 0 ? -w[i] : w[i]) > mx) mx = w[i] < 0 ? -w[i] : w[i];
        foreach (w[i]) begin
          a = w[i] < 0 ? -w[i] : w[i];
          if (mx > lim) a = (a * lim) / mx;
          a = (a * rpm_q) >> 15;
          w[i] = w[i] < 0 ? -int'(a) : int'(a);
        end
        r.cvx = 16'(c[0]);
        r.cvy = 16'(c[1]);
        r.cwz = 16'(c[2]);
        r.w0 = 15'(w[0]);
        r.w1 = 15'(w[1]);
        r.w2 = 15'(w[2]);
        r.w3 = 15'(w[3]);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on word %0d: %s got %0d expected %0d", words_seen, what, got, want);
    mismatches++;
  endtask

  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_taken) begin
        if (pending_frames.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_frame <= pending_frames[0];
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= $urandom_range(99) < recv_idle_pct;
    end
  end

  always @(posedge clk) begin
    speeds_t e, r;
    if (!rst) begin
      in_taken = in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        void'(pending_frames.pop_front());
        expected_speeds.push_back(wheel_speeds(drv_frame));
        frames_sent++;
      end
      if (out_valid && !out_stall) begin
        r = {drive_state, gear, cmd_vx, cmd_vy, cmd_wz,
             wheel_0_rpm, wheel_1_rpm, wheel_2_rpm, wheel_3_rpm};
        if (expected_speeds.size() == 0) begin
          $display("word %0d arrived with nothing expected", words_seen);
          mismatches++;
        end else begin
          e = expected_speeds.pop_front();
          if (r.state != e.state) report_mismatch("drive_state", r.state, e.state);
          if (r.gear != e.gear) report_mismatch("gear", r.gear, e.gear);
          if (r.cvx != e.cvx) report_mismatch("cmd_vx", $signed(r.cvx), $signed(e.cvx));
          if (r.cvy != e.cvy) report_mismatch("cmd_vy", $signed(r.cvy), $signed(e.cvy));
          if (r.cwz != e.cwz) report_mismatch("cmd_wz", $signed(r.cwz), $signed(e.cwz));
          if (r.w0 != e.w0) report_mismatch("wheel_0_rpm", $signed(r.w0), $signed(e.w0));
          if (r.w1 != e.w1) report_mismatch("wheel_1_rpm", $signed(r.w1), $signed(e.w1));
          if (r.w2 != e.w2) report_mismatch("wheel_2_rpm", $signed(r.w2), $signed(e.w2));
          if (r.w3 != e.w3) report_mismatch("wheel_3_rpm", $signed(r.w3), $signed(e.w3));
          if (e.state == DS_ENABLED) n_enabled++;
          else if (e.state == DS_LOCKED) n_locked++;
          else n_offline++;
        end
        words_seen++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else if (pending_frames.size() > 0 || expected_speeds.size() > 0) idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
        timed_out = 1'b1;
        $display("rc_to_mecanum_wheel_speeds_top_tb NOT OK");
        $finish;
      end
    end
  end

  task automatic write_reg(reg_index_t idx, int unsigned value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * idx);
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_DEADZONE:   dz_q = value & 32'h3FF;
      REG_FULL_SCALE: full_q = value & 32'h7FF;
      REG_THRESHOLD:  thr_q = value & 32'h7FF;
      REG_LOW_LIMIT:  limit_q[GEAR_LOW] = value & 32'h7FFF;
      REG_MED_LIMIT:  limit_q[GEAR_MEDIUM] = value & 32'h7FFF;
      REG_HIGH_LIMIT: limit_q[GEAR_HIGH] = value & 32'h7FFF;
      REG_MOTOR_RPM:  rpm_q = value & 32'h3FFF;
      default: ;
    endcase
  endtask

  task automatic settle;
    while (pending_frames.size() > 0 || expected_speeds.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [11:0] stick_value();
    case ($urandom_range(5))
      0: return 12'($urandom_range(60));
      1: return -12'($urandom_range(60));
      2: return $urandom_range(1) ? 12'h7FF : 12'h800;
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    f.online = $urandom_range(9) != 0;
    f.en_sw = $urandom_range(3) != 0 ? 12'(-int'($urandom_range(2048, thr_q + 1)))
                                     : 12'($urandom);
    case ($urandom_range(3))
      0: f.gear_sw = 12'(-int'($urandom_range(2048, thr_q + 1)));
      1: f.gear_sw = 12'($urandom_range(2047, thr_q + 1 > 2047 ? 2047 : thr_q + 1));
      2: f.gear_sw = 12'($urandom_range(thr_q, 0) * ($urandom_range(1) ? 1 : -1));
      default: f.gear_sw = 12'($urandom);
    endcase
    f.vx = stick_value();
    f.vy = stick_value();
    f.wz = stick_value();
    return f;
  endfunction

  task automatic run_phase(int count, int unsigned s_idle, int unsigned r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (count) pending_frames.push_back(random_frame());
    settle();
  endtask

  initial begin
    dz_q = DEADZONE_RST;
    full_q = FULL_RST;
    thr_q = THRESHOLD_RST;
    limit_q[GEAR_LOW] = LOW_RST;
    limit_q[GEAR_MEDIUM] = MEDIUM_RST;
    limit_q[GEAR_HIGH] = HIGH_RST;
    rpm_q = RPM_RST;
    send_idle_pct = 14;
    recv_idle_pct = 74;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: offline, locked, each gear, deadzone edges and full-scale sticks.
    pending_frames.push_back('{1'b0, 12'h800, 12'h800, 12'h7FF, 12'h800, 12'h7FF});
    pending_frames.push_back('{1'b1, 12'h7FF, 12'h800, 12'h7FF, 12'h7FF, 12'h7FF});
    pending_frames.push_back('{1'b1, -12'd400, 12'd0, 12'd500, 12'd0, 12'd0});
    pending_frames.push_back('{1'b1, -12'd401, 12'd401, 12'd820, 12'd0, 12'd0});
    pending_frames.push_back('{1'b1, 12'h800, 12'd400, 12'd20, -12'd21, 12'd21});
    pending_frames.push_back('{1'b1, 12'h800, -12'd400, 12'h7FF, 12'h7FF, 12'h7FF});
    pending_frames.push_back('{1'b1, 12'h800, -12'd401, 12'h800, 12'h800, 12'h800});
    pending_frames.push_back('{1'b1, 12'h800, 12'h800, 12'h7FF, 12'h800, 12'h7FF});
    pending_frames.push_back('{1'b1, 12'h800, 12'h7FF, 12'd819, -12'd819, 12'd0});
    pending_frames.push_back('{1'b1, 12'h800, 12'h800, 12'hFFF, 12'h001, 12'h555});
    pending_frames.push_back('{1'b1, 12'h800, 12'h000, 12'hAAA, 12'h555, 12'hAAA});
    settle();

    run_phase(300, 14, 74);

    write_reg(REG_DEADZONE, 1023);
    write_reg(REG_FULL_SCALE, 100);
    write_reg(REG_THRESHOLD, 0);
    write_reg(REG_LOW_LIMIT, 32767);
    write_reg(REG_MED_LIMIT, 0);
    write_reg(REG_HIGH_LIMIT, 1);
    write_reg(REG_MOTOR_RPM, 16383);
    pending_frames.push_back('{1'b1, 12'h800, 12'h001, 12'd1024, 12'h800, 12'd1023});
    run_phase(150, 74, 14);

    write_reg(REG_DEADZONE, 0);
    write_reg(REG_FULL_SCALE, 2047);
    write_reg(REG_THRESHOLD, 2047);
    write_reg(REG_MOTOR_RPM, 0);
    pending_frames.push_back('{1'b1, 12'h800, 12'h800, 12'h001, 12'hFFF, 12'h800});
    run_phase(150, 74, 14);

    write_reg(REG_DEADZONE, 5);
    write_reg(REG_FULL_SCALE, 1);
    write_reg(REG_THRESHOLD, 37);
    write_reg(REG_LOW_LIMIT, 12000);
    write_reg(REG_MED_LIMIT, 32767);
    write_reg(REG_HIGH_LIMIT, 20000);
    write_reg(REG_MOTOR_RPM, 12345);
    run_phase(150, 0, 0);

    write_reg(REG_DEADZONE, $urandom_range(200));
    write_reg(REG_FULL_SCALE, $urandom_range(2047, 300));
    write_reg(REG_THRESHOLD, $urandom_range(1500));
    write_reg(REG_LOW_LIMIT, $urandom_range(32767));
    write_reg(REG_MED_LIMIT, $urandom_range(32767));
    write_reg(REG_HIGH_LIMIT, $urandom_range(32767));
    write_reg(REG_MOTOR_RPM, $urandom_range(16383));
    run_phase(300, 0, 0);

    $display("Covered %0d frames: %0d enabled, %0d locked, %0d offline, over five settings.",
             frames_sent, n_enabled, n_locked, n_offline);
    if (mismatches == 0) begin
      $display("rc_to_mecanum_wheel_speeds_top_tb OK");
    end else begin
      $display("rc_to_mecanum_wheel_speeds_top_tb NOT OK");
    end
    $finish;
  end

endmodule
